/* rtl/msb_pkg.sv */
package msb_pkg;

  localparam int unsigned SCREEN_WIDTH  = 128;
  localparam int unsigned SCREEN_HEIGHT = 64;
  localparam int unsigned STORE_DEPTH   = 1024;
  localparam int unsigned ADDR_W        = $clog2(STORE_DEPTH);
  localparam int unsigned QDEPTH        = 4;
  localparam int unsigned Q_PTR_W       = $clog2(QDEPTH);
  localparam int unsigned Q_CNT_W       = $clog2(QDEPTH + 1);

  typedef enum logic [1:0] {
    MODE_BLIT  = 2'd0,
    MODE_READ  = 2'd1,
    MODE_WRITE = 2'd2,
    MODE_NOP   = 2'd3
  } item_mode_t;

  typedef enum logic [1:0] {
    DRAW_TRANSPARENT = 2'd0,
    DRAW_SOLID       = 2'd1,
    DRAW_MASKED      = 2'd2
  } draw_mode_t;

  typedef enum logic [2:0] {
    REG_DEST_X        = 3'd0,
    REG_DEST_Y        = 3'd1,
    REG_SPRITE_WIDTH  = 3'd2,
    REG_SPRITE_HEIGHT = 3'd3,
    REG_DRAW_MODE     = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    ST_CLEAR  = 2'd0,
    ST_RUN    = 2'd1,
    ST_SECOND = 2'd2
  } state_t;

  typedef enum logic [2:0] {
    OP_NONE    = 3'd0,
    OP_READ    = 3'd1,
    OP_WRITE   = 3'd2,
    OP_BLIT_LO = 3'd3,
    OP_BLIT_HI = 3'd4
  } op_kind_t;

  typedef struct packed {
    logic [8:0] dest_x;
    logic [8:0] dest_y;
    logic [7:0] sprite_width;
    logic [7:0] sprite_height;
    logic [1:0] draw_mode;
  } cfg_t;

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [7:0]        wmask;
    logic [7:0]        wdata;
  } subop_t;

  typedef struct packed {
    subop_t     lo;
    subop_t     hi;
    logic [7:0] col_nxt;
    logic [4:0] page_nxt;
    logic       done;
  } blit_plan_t;

  typedef struct packed {
    logic [7:0] read_data;
    logic       blit_done;
  } result_t;

endpackage

/* rtl/msb_in_if.sv */
interface msb_in_if;
  logic                      valid;
  logic                      ready;
  logic [1:0]                mode;
  logic [7:0]                src_bits;
  logic [7:0]                src_mask;
  logic [msb_pkg::ADDR_W-1:0] fb_index;
  logic [7:0]                fb_data;

  modport source (output valid, mode, src_bits, src_mask, fb_index, fb_data, input ready);
  modport sink   (input valid, mode, src_bits, src_mask, fb_index, fb_data, output ready);
endinterface

/* rtl/msb_out_if.sv */
interface msb_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic       blit_done;

  modport source (output valid, read_data, blit_done, input ready);
  modport sink   (input valid, read_data, blit_done, output ready);
endinterface

/* rtl/msb_cfg_if.sv */
interface msb_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] index;
  logic [8:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

/* rtl/msb_blit_calc.sv */
module msb_blit_calc (
  input  msb_pkg::cfg_t       cfg,
  input  logic [7:0]          col,
  input  logic [4:0]          page,
  input  logic [7:0]          src_bits,
  input  logic [7:0]          src_mask,
  output msb_pkg::blit_plan_t plan
);
  import msb_pkg::*;

  localparam int unsigned ROW_W  = 11;
  localparam int unsigned FULL_W = 16;

  logic [8:0]       h_sum;
  logic [5:0]       pages;
  logic             empty;
  logic             in_sprite;
  logic             draw_ok;
  logic             page_last;
  logic             col_last;
  logic [7:0]       en8;
  logic [7:0]       row8;
  logic             sel;
  logic [ROW_W-1:0] base_row;
  logic [2:0]       shift;
  logic [7:0]       pa;
  logic [7:0]       pb;
  logic [ROW_W-1:0] sx;
  logic             sx_ok;
  logic [15:0]      wide_en;
  logic [15:0]      wide_on;

  function automatic subop_t make_subop(logic [7:0] pg, logic [7:0] en, logic [7:0] on,
                                        logic [ADDR_W-1:0] sxv, logic sx_good);
    subop_t             op;
    logic [FULL_W-1:0]  addr_full;
    logic [9:0]         sy;
    logic               ok;
    addr_full = FULL_W'(sxv) + FULL_W'(pg[6:0]) * FULL_W'(SCREEN_WIDTH);
    ok        = sx_good && !pg[7] && (addr_full < FULL_W'(STORE_DEPTH));
    op.addr   = addr_full[ADDR_W-1:0];
    op.wdata  = on;
    for (int j = 0; j < 8; j++) begin
      sy = {pg[6:0], 3'(j)};
      op.wmask[j] = ok && en[j] && (sy < 10'(SCREEN_HEIGHT));
    end
    return op;
  endfunction

  always_comb begin
    h_sum     = {1'b0, cfg.sprite_height} + 9'd7;
    pages     = h_sum[8:3];
    empty     = (cfg.sprite_width == 8'd0) || (pages == 6'd0);
    in_sprite = (col < cfg.sprite_width) && ({1'b0, page} < pages);
    draw_ok   = !empty && in_sprite;
    page_last = ({1'b0, page} + 6'd1) >= pages;
    col_last  = ({1'b0, col} + 9'd1) >= {1'b0, cfg.sprite_width};

    plan.col_nxt  = col;
    plan.page_nxt = page;
    plan.done     = 1'b0;
    if (empty) begin
      plan.col_nxt  = '0;
      plan.page_nxt = '0;
      plan.done     = 1'b1;
    end else if (page_last) begin
      plan.page_nxt = '0;
      if (col_last) begin
        plan.col_nxt = '0;
        plan.done    = 1'b1;
      end else begin
        plan.col_nxt = col + 8'd1;
      end
    end else begin
      plan.page_nxt = page + 5'd1;
    end

    for (int b = 0; b < 8; b++) begin
      row8 = {page, 3'(b)};
      case (cfg.draw_mode)
        DRAW_TRANSPARENT: sel = src_bits[b];
        DRAW_SOLID:       sel = 1'b1;
        default:          sel = src_mask[b];
      endcase
      en8[b] = draw_ok && (row8 < cfg.sprite_height) && sel;
    end

    base_row = {{2{cfg.dest_y[8]}}, cfg.dest_y} + {3'b000, page, 3'b000};
    shift    = base_row[2:0];
    pa       = base_row[ROW_W-1:3];
    pb       = pa + 8'd1;
    sx       = {{2{cfg.dest_x[8]}}, cfg.dest_x} + {3'b000, col};
    sx_ok    = !sx[ROW_W-1] && (sx[ADDR_W-1:0] < ADDR_W'(SCREEN_WIDTH));
    wide_en  = {8'd0, en8} << shift;
    wide_on  = {8'd0, src_bits} << shift;

    plan.lo = make_subop(pa, wide_en[7:0], wide_on[7:0], sx[ADDR_W-1:0], sx_ok);
    plan.hi = make_subop(pb, wide_en[15:8], wide_on[15:8], sx[ADDR_W-1:0], sx_ok);
  end

endmodule

/* rtl/masked_sprite_blitter_top.sv */
// Page-organized 1-bit framebuffer with a sprite blitter. After reset the block
// clears all 1024 bytes of the frame store, one byte per cycle, and takes no
// items meanwhile (configuration writes are taken at any time). Read, write and
// no-op items need one frame store access each; a blit item needs two, because its
// byte can straddle two framebuffer pages and the single frame store write port
// performs one read-modify-write per cycle. Results pass through the access stage
// into a four-entry output queue, so the input keeps moving while the output
// stalls until four results are outstanding.
module masked_sprite_blitter_top (
  input  logic      clk,
  input  logic      rst_n,
  msb_cfg_if.sink   cfg_ch,
  msb_in_if.sink    in_ch,
  msb_out_if.source out_ch
);
  import msb_pkg::*;

  logic [7:0]         frame_mem [STORE_DEPTH];
  logic [7:0]         mem_q_r;

  state_t             state_r, state_nxt;
  logic [ADDR_W-1:0]  clr_addr_r;
  cfg_t               cfg_r;
  logic [7:0]         col_r;
  logic [4:0]         page_r;

  logic               in_ready_c, clearing_c, second_c;
  logic               in_xfer, out_xfer, cfg_xfer;
  blit_plan_t         plan;

  logic               iss_valid;
  op_kind_t           iss_kind;
  subop_t             iss_op;
  logic               iss_done;

  subop_t             hold_op_r;
  logic               hold_done_r;

  logic               s1_valid_r;
  op_kind_t           s1_kind_r;
  subop_t             s1_op_r;
  logic               s1_done_r;
  logic [7:0]         s1_old, s1_new;
  logic               s1_we, s1_push;
  result_t            s1_res;

  logic               last_valid_r;
  logic [ADDR_W-1:0]  last_addr_r;
  logic [7:0]         last_data_r;

  result_t            q_mem [QDEPTH];
  logic [Q_PTR_W-1:0] q_wr_r, q_rd_r;
  logic [Q_CNT_W-1:0] q_cnt_r, credit_r;

  msb_blit_calc u_calc (
    .cfg      (cfg_r),
    .col      (col_r),
    .page     (page_r),
    .src_bits (in_ch.src_bits),
    .src_mask (in_ch.src_mask),
    .plan     (plan)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (clr_addr_r == ADDR_W'(STORE_DEPTH - 1)) state_nxt = ST_RUN;
      end
      ST_RUN: begin
        if (in_xfer && (in_ch.mode == MODE_BLIT)) state_nxt = ST_SECOND;
      end
      ST_SECOND: state_nxt = ST_RUN;
      default:   state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready_c = 1'b0;
    clearing_c = 1'b0;
    second_c   = 1'b0;
    case (state_r)
      ST_CLEAR:  clearing_c = 1'b1;
      ST_RUN:    in_ready_c = credit_r < Q_CNT_W'(QDEPTH);
      ST_SECOND: second_c = 1'b1;
      default:   clearing_c = 1'b1;
    endcase
  end

  assign in_ch.ready  = in_ready_c;
  assign cfg_ch.ready = 1'b1;
  assign in_xfer      = in_ch.valid && in_ready_c;
  assign cfg_xfer     = cfg_ch.valid;
  assign out_xfer     = out_ch.valid && out_ch.ready;

  always_comb begin
    iss_valid = 1'b0;
    iss_kind  = OP_NONE;
    iss_op    = '0;
    iss_done  = 1'b0;
    if (second_c) begin
      iss_valid = 1'b1;
      iss_kind  = OP_BLIT_HI;
      iss_op    = hold_op_r;
      iss_done  = hold_done_r;
    end else if (in_xfer) begin
      iss_valid = 1'b1;
      case (item_mode_t'(in_ch.mode))
        MODE_BLIT: begin
          iss_kind = OP_BLIT_LO;
          iss_op   = plan.lo;
        end
        MODE_READ: begin
          iss_kind    = OP_READ;
          iss_op.addr = in_ch.fb_index;
        end
        MODE_WRITE: begin
          iss_kind     = OP_WRITE;
          iss_op.addr  = in_ch.fb_index;
          iss_op.wmask = 8'hFF;
          iss_op.wdata = in_ch.fb_data;
        end
        default: iss_kind = OP_NONE;
      endcase
    end
  end

  always_comb begin
    s1_old  = (last_valid_r && (last_addr_r == s1_op_r.addr)) ? last_data_r : mem_q_r;
    s1_new  = (s1_old & ~s1_op_r.wmask) | (s1_op_r.wdata & s1_op_r.wmask);
    s1_we   = s1_valid_r && (s1_op_r.wmask != 8'd0);
    s1_push = s1_valid_r && (s1_kind_r != OP_BLIT_LO);
    s1_res.read_data = (s1_kind_r == OP_READ) ? s1_old : 8'd0;
    s1_res.blit_done = (s1_kind_r == OP_BLIT_HI) ? s1_done_r : 1'b0;
  end

  always_ff @(posedge clk) begin
    if (clearing_c) begin
      frame_mem[clr_addr_r] <= 8'd0;
    end else if (s1_we) begin
      frame_mem[s1_op_r.addr] <= s1_new;
    end
    if (iss_valid) begin
      mem_q_r <= frame_mem[iss_op.addr];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_CLEAR;
      clr_addr_r   <= '0;
      cfg_r        <= '0;
      col_r        <= '0;
      page_r       <= '0;
      s1_valid_r   <= 1'b0;
      last_valid_r <= 1'b0;
      q_wr_r       <= '0;
      q_rd_r       <= '0;
      q_cnt_r      <= '0;
      credit_r     <= '0;
    end else begin
      state_r    <= state_nxt;
      s1_valid_r <= iss_valid;
      if (clearing_c) begin
        clr_addr_r <= clr_addr_r + ADDR_W'(1);
      end
      if (clearing_c) begin
        last_valid_r <= 1'b0;
      end else if (s1_we) begin
        last_valid_r <= 1'b1;
      end
      if (cfg_xfer) begin
        case (reg_index_t'(cfg_ch.index))
          REG_DEST_X: begin
            cfg_r.dest_x <= cfg_ch.data;
            col_r        <= '0;
            page_r       <= '0;
          end
          REG_DEST_Y: begin
            cfg_r.dest_y <= cfg_ch.data;
            col_r        <= '0;
            page_r       <= '0;
          end
          REG_SPRITE_WIDTH: begin
            cfg_r.sprite_width <= cfg_ch.data[7:0];
            col_r              <= '0;
            page_r             <= '0;
          end
          REG_SPRITE_HEIGHT: begin
            cfg_r.sprite_height <= cfg_ch.data[7:0];
            col_r               <= '0;
            page_r              <= '0;
          end
          REG_DRAW_MODE: begin
            cfg_r.draw_mode <= cfg_ch.data[1:0];
            col_r           <= '0;
            page_r          <= '0;
          end
          default: begin
          end
        endcase
      end else if (in_xfer && (in_ch.mode == MODE_BLIT)) begin
        col_r  <= plan.col_nxt;
        page_r <= plan.page_nxt;
      end
      if (s1_push) begin
        q_wr_r <= q_wr_r + Q_PTR_W'(1);
      end
      if (out_xfer) begin
        q_rd_r <= q_rd_r + Q_PTR_W'(1);
      end
      q_cnt_r  <= q_cnt_r + Q_CNT_W'(s1_push) - Q_CNT_W'(out_xfer);
      credit_r <= credit_r + Q_CNT_W'(in_xfer) - Q_CNT_W'(out_xfer);
    end
  end

  always_ff @(posedge clk) begin
    s1_kind_r <= iss_kind;
    s1_op_r   <= iss_op;
    s1_done_r <= iss_done;
    if (in_xfer) begin
      hold_op_r   <= plan.hi;
      hold_done_r <= plan.done;
    end
    if (s1_we) begin
      last_addr_r <= s1_op_r.addr;
      last_data_r <= s1_new;
    end
    if (s1_push) begin
      q_mem[q_wr_r] <= s1_res;
    end
  end

  assign out_ch.valid     = q_cnt_r != '0;
  assign out_ch.read_data = q_mem[q_rd_r].read_data;
  assign out_ch.blit_done = q_mem[q_rd_r].blit_done;

  a_credit_bound: assert property (@(posedge clk) disable iff (!rst_n)
    credit_r <= Q_CNT_W'(QDEPTH))
    else $error("result credit exceeds queue depth");

  a_queue_within_credit: assert property (@(posedge clk) disable iff (!rst_n)
    q_cnt_r <= credit_r)
    else $error("queue holds more results than items in flight");

  a_hi_follows_lo: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_valid_r && (s1_kind_r == OP_BLIT_LO)) |=> (s1_valid_r && (s1_kind_r == OP_BLIT_HI)))
    else $error("upper blit access did not follow lower one");

  a_clear_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    clearing_c |-> (!s1_valid_r && !iss_valid))
    else $error("frame store access during clearing pass");

endmodule

/* tb/tb_top.sv */
module tb_top;
  import msb_pkg::*;

  localparam logic [1:0] DRAW_UNDEF = 2'd3;
  localparam logic [2:0] REG_UNUSED = 3'd5;
  localparam int unsigned RUN_ITEMS = 750;
  localparam int unsigned CALM_ITEMS = 650;

  typedef struct {
    item_mode_t        mode;
    logic [7:0]        bits;
    logic [7:0]        mask;
    logic [ADDR_W-1:0] index;
    logic [7:0]        data;
  } fb_item_t;

  typedef struct {
    bit         is_reg;
    logic [2:0] reg_idx;
    logic [8:0] reg_val;
    fb_item_t   item;
    bit         typed;
    result_t    want;
  } script_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;

  msb_cfg_if cfg_ch();
  msb_in_if  in_ch();
  msb_out_if out_ch();

  masked_sprite_blitter_top u_top (
    .clk    (clk),
    .rst_n  (rst_n),
    .cfg_ch (cfg_ch),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  always #5 clk = ~clk;

  // framebuffer image and blitter walk state
  logic [7:0]  fb_image [STORE_DEPTH];
  logic [8:0]  cur_dest_x;
  logic [8:0]  cur_dest_y;
  logic [7:0]  cur_width;
  logic [7:0]  cur_height;
  logic [1:0]  cur_draw;
  int unsigned walk_col;
  int unsigned walk_page;

  result_t     pending_results[$];
  script_row_t script[$];

  bit calm;
  int errors;
  int items_sent;
  int blits_sent;
  int reads_sent;
  int writes_sent;
  int reg_writes;
  int sprites_done;
  int results_checked;

  function automatic void plot_pixel(int sx, int sy, bit on);
    int unsigned addr;
    if (sx < 0 || sx >= int'(SCREEN_WIDTH) || sy < 0 || sy >= int'(SCREEN_HEIGHT)) return;
    addr = sx + (sy / 8) * SCREEN_WIDTH;
    if (addr >= STORE_DEPTH) return;
    fb_image[addr][sy % 8] = on;
  endfunction

  function automatic bit blit_byte(logic [7:0] bits, logic [7:0] mask);
    int unsigned pages;
    int          sx;
    int          dy;
    int unsigned row;
    bit          wr;
    bit          last;
    pages = (int'(cur_height) + 7) / 8;
    if (cur_width == 0 || pages == 0) begin
      walk_col = 0;
      walk_page = 0;
      sprites_done++;
      return 1'b1;
    end
    if (walk_col < cur_width && walk_page < pages) begin
      sx = $signed(cur_dest_x);
      sx = sx + int'(walk_col);
      dy = $signed(cur_dest_y);
      for (int b = 0; b < 8; b++) begin
        row = walk_page * 8 + b;
        if (row >= cur_height) break;
        if (cur_draw == DRAW_TRANSPARENT) wr = bits[b];
        else if (cur_draw == DRAW_SOLID) wr = 1'b1;
        else wr = mask[b];
        if (wr) plot_pixel(sx, dy + int'(row), bits[b]);
      end
    end
    last = 1'b0;
    if (walk_page + 1 >= pages) begin
      walk_page = 0;
      if (walk_col + 1 >= cur_width) begin
        walk_col = 0;
        last = 1'b1;
      end else begin
        walk_col = (walk_col + 1) & 8'hFF;
      end
    end else begin
      walk_page = (walk_page + 1) & 5'h1F;
    end
    if (last) sprites_done++;
    return last;
  endfunction

  function automatic result_t apply_item(fb_item_t it);
    result_t res;
    res = '0;
    case (it.mode)
      MODE_BLIT:  res.blit_done = blit_byte(it.bits, it.mask);
      MODE_READ:  res.read_data = fb_image[it.index];
      MODE_WRITE: fb_image[it.index] = it.data;
      default: ;
    endcase
    return res;
  endfunction

  function automatic void apply_reg(logic [2:0] idx, logic [8:0] val);
    case (idx)
      REG_DEST_X:        cur_dest_x = val;
      REG_DEST_Y:        cur_dest_y = val;
      REG_SPRITE_WIDTH:  cur_width = val[7:0];
      REG_SPRITE_HEIGHT: cur_height = val[7:0];
      REG_DRAW_MODE:     cur_draw = val[1:0];
      default: return;
    endcase
    walk_col = 0;
    walk_page = 0;
  endfunction

  // byte address somewhere around the current sprite
  function automatic logic [ADDR_W-1:0] near_sprite();
    int dx;
    int dy;
    int c;
    int p;
    dx = $signed(cur_dest_x);
    dy = $signed(cur_dest_y);
    c = dx + int'($urandom_range(0, cur_width));
    c = ((c % int'(SCREEN_WIDTH)) + int'(SCREEN_WIDTH)) % int'(SCREEN_WIDTH);
    p = (dy >>> 3) + int'($urandom_range(0, 3));
    p = ((p % 8) + 8) % 8;
    return ADDR_W'(p * int'(SCREEN_WIDTH) + c);
  endfunction

  function automatic void add_reg(logic [2:0] idx, logic [8:0] val);
    script_row_t r;
    r.is_reg = 1'b1;
    r.reg_idx = idx;
    r.reg_val = val;
    r.typed = 1'b0;
    r.want = '0;
    script.push_back(r);
  endfunction

  function automatic void add_item(item_mode_t mode, logic [7:0] bits, logic [7:0] mask,
                                   logic [ADDR_W-1:0] index, logic [7:0] data,
                                   bit typed, logic [7:0] rd, logic done);
    script_row_t r;
    r.is_reg = 1'b0;
    r.reg_idx = '0;
    r.reg_val = '0;
    r.item.mode = mode;
    r.item.bits = bits;
    r.item.mask = mask;
    r.item.index = index;
    r.item.data = data;
    r.typed = typed;
    r.want.read_data = rd;
    r.want.blit_done = done;
    script.push_back(r);
  endfunction

  function automatic void flag(string what, result_t want, result_t got);
    errors++;
    if (errors <= 10)
      $display("mismatch (%s): expected data %02h done %0b, got data %02h done %0b",
               what, want.read_data, want.blit_done, got.read_data, got.blit_done);
  endfunction

  task automatic put_item(fb_item_t it, bit typed, result_t want);
    result_t calc;
    @(negedge clk);
    in_ch.valid    <= 1'b1;
    in_ch.mode     <= it.mode;
    in_ch.src_bits <= it.bits;
    in_ch.src_mask <= it.mask;
    in_ch.fb_index <= it.index;
    in_ch.fb_data  <= it.data;
    do @(posedge clk); while (!in_ch.ready);
    calc = apply_item(it);
    pending_results.push_back(typed ? want : calc);
    items_sent++;
    case (it.mode)
      MODE_BLIT:  blits_sent++;
      MODE_READ:  reads_sent++;
      MODE_WRITE: writes_sent++;
      default: ;
    endcase
  endtask

  task automatic idle_in(int n);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // drain all results, then write one register
  task automatic write_reg(logic [2:0] idx, logic [8:0] val);
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= val;
    do @(posedge clk); while (!cfg_ch.ready);
    apply_reg(idx, val);
    reg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic new_phase();
    logic [8:0] v;
    int         r;
    if ($urandom_range(0, 9) == 0) write_reg(3'($urandom_range(REG_UNUSED, 7)), 9'($urandom));
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      if (r == 0) v = 9'h100;
      else if (r == 1) v = 9'h0FF;
      else if (r < 5) v = 9'($urandom);
      else v = 9'(int'($urandom_range(0, 150)) - 16);
      write_reg(REG_DEST_X, v);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      if (r == 0) v = 9'h100;
      else if (r == 1) v = 9'h0FF;
      else if (r < 5) v = 9'($urandom);
      else v = 9'(int'($urandom_range(0, 80)) - 12);
      write_reg(REG_DEST_Y, v);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      v = {1'($urandom), 8'($urandom_range(1, 8))};
      if (r == 0) v[7:0] = 8'h00;
      else if (r == 1) v[7:0] = 8'hFF;
      write_reg(REG_SPRITE_WIDTH, v);
    end
    if ($urandom_range(0, 9) < 7) begin
      r = $urandom_range(0, 19);
      v = {1'($urandom), 8'($urandom_range(1, 24))};
      if (r == 0) v[7:0] = 8'h00;
      else if (r == 1) v[7:0] = 8'hFF;
      write_reg(REG_SPRITE_HEIGHT, v);
    end
    if ($urandom_range(0, 9) < 7) write_reg(REG_DRAW_MODE, {7'($urandom), 2'($urandom)});
  endtask

  task automatic random_batch(int n);
    fb_item_t it;
    result_t  no_want;
    int       r;
    no_want = '0;
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 60) it.mode = MODE_BLIT;
      else if (r < 82) it.mode = MODE_READ;
      else if (r < 95) it.mode = MODE_WRITE;
      else it.mode = MODE_NOP;
      it.bits = 8'($urandom);
      it.mask = 8'($urandom);
      it.data = 8'($urandom);
      it.index = $urandom_range(0, 1) ? near_sprite() : ADDR_W'($urandom);
      if (!calm && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 12));
      put_item(it, 1'b0, no_want);
      calm = (items_sent >= CALM_ITEMS);
    end
  endtask

  // result sink: stall bursts mixed with runs of steady ready
  initial begin
    int stall_left;
    int run_left;
    stall_left = 0;
    run_left = 0;
    out_ch.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (calm) begin
        out_ch.ready <= 1'b1;
      end else if (stall_left > 0) begin
        stall_left--;
      end else if (run_left > 0) begin
        run_left--;
        out_ch.ready <= 1'b1;
      end else if ($urandom_range(0, 1) == 0) begin
        out_ch.ready <= 1'b0;
        stall_left = $urandom_range(0, 11);
      end else begin
        out_ch.ready <= 1'b1;
        run_left = $urandom_range(0, 40);
      end
    end
  end

  always @(posedge clk) begin : result_check
    result_t got;
    result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      got.read_data = out_ch.read_data;
      got.blit_done = out_ch.blit_done;
      results_checked++;
      if (pending_results.size() == 0) begin
        flag("result with nothing pending", '0, got);
      end else begin
        want = pending_results.pop_front();
        if (got.read_data !== want.read_data || got.blit_done !== want.blit_done)
          flag("field differs", want, got);
      end
    end
  end

  initial begin
    #4000000;
    $display("CHECK FAILED");
    $finish;
  end

  initial begin
    in_ch.valid = 1'b0;
    in_ch.mode = MODE_NOP;
    in_ch.src_bits = '0;
    in_ch.src_mask = '0;
    in_ch.fb_index = '0;
    in_ch.fb_data = '0;
    cfg_ch.valid = 1'b0;
    cfg_ch.index = '0;
    cfg_ch.data = '0;
    foreach (fb_image[a]) fb_image[a] = '0;
    cur_dest_x = '0;
    cur_dest_y = '0;
    cur_width = '0;
    cur_height = '0;
    cur_draw = '0;
    walk_col = 0;
    walk_page = 0;
    calm = 1'b0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    add_item(MODE_READ,  8'h00, 8'h00, 10'h000, 8'h00, 1'b1, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h3FF, 8'h00, 1'b1, 8'h00, 1'b0);
    add_item(MODE_WRITE, 8'h00, 8'h00, 10'h3FF, 8'hFF, 1'b1, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h3FF, 8'h00, 1'b1, 8'hFF, 1'b0);
    add_item(MODE_WRITE, 8'h00, 8'h00, 10'h000, 8'hA5, 1'b1, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h000, 8'h00, 1'b1, 8'hA5, 1'b0);
    add_item(MODE_NOP,   8'hFF, 8'hFF, 10'h3FF, 8'hFF, 1'b1, 8'h00, 1'b0);
    // empty sprite: zero width, then zero height
    add_item(MODE_BLIT,  8'hFF, 8'hFF, 10'h000, 8'h00, 1'b1, 8'h00, 1'b1);
    add_reg(REG_SPRITE_WIDTH, 9'd2);
    add_item(MODE_BLIT,  8'hFF, 8'h00, 10'h000, 8'h00, 1'b1, 8'h00, 1'b1);
    // unaligned row, height cut inside the second page
    add_reg(REG_SPRITE_HEIGHT, 9'd13);
    add_reg(REG_DEST_Y, 9'd3);
    add_reg(REG_DRAW_MODE, 9'(DRAW_TRANSPARENT));
    add_item(MODE_BLIT,  8'hFF, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'hFF, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'h55, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'hAA, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h080, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h001, 8'h00, 1'b0, 8'h00, 1'b0);
    // solid, left edge off screen
    add_reg(REG_DRAW_MODE, 9'(DRAW_SOLID));
    add_reg(REG_DEST_X, 9'h1FF);
    add_item(MODE_BLIT,  8'h00, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'h0F, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'h00, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'hF0, 8'h00, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    // undefined draw mode, clipped at right and bottom, ignored register index
    add_reg(REG_DRAW_MODE, 9'(DRAW_UNDEF));
    add_reg(REG_DEST_X, 9'd127);
    add_reg(REG_DEST_Y, 9'd60);
    add_reg(REG_UNUSED, 9'h1FF);
    add_item(MODE_BLIT,  8'hFF, 8'h0F, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'h00, 8'hFF, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'hAA, 8'h55, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_BLIT,  8'h55, 8'hFF, 10'h000, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h07F, 8'h00, 1'b0, 8'h00, 1'b0);
    add_item(MODE_READ,  8'h00, 8'h00, 10'h3FF, 8'h00, 1'b0, 8'h00, 1'b0);

    foreach (script[i]) begin
      if (script[i].is_reg) write_reg(script[i].reg_idx, script[i].reg_val);
      else put_item(script[i].item, script[i].typed, script[i].want);
    end

    while (items_sent < RUN_ITEMS) begin
      new_phase();
      random_batch($urandom_range(8, 40));
    end

    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("covered %0d items: %0d blits, %0d reads, %0d raw writes; %0d register writes",
             items_sent, blits_sent, reads_sent, writes_sent, reg_writes);
    $display("%0d sprites finished, %0d results checked", sprites_done, results_checked);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", errors);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
